FILE: hdl/mhsic_pkg.sv
// ----------------------------------------------------------------------------
// mhsic_pkg
// shared types, widths and register codes for the magnetometer correction core
// ----------------------------------------------------------------------------
`default_nettype none

package mhsic_pkg;

    // sample and coefficient format
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 13;
    localparam int COEF_W         = 16;
    localparam int NUM_AXES       = 3;
    localparam int ROW_W          = NUM_AXES * COEF_W;
    localparam int OUT_W          = 21;

    // datapath widths
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]       t_diff;
    typedef logic signed [PROD_W-1:0]       t_prod;
    typedef logic signed [SUM_W-1:0]        t_sum;
    typedef logic signed [OUT_W-1:0]        t_out;
    typedef logic signed [COEF_W-1:0]       t_coef;
    typedef logic [ROW_W-1:0]               t_row;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_EN = 3'd0,
        REG_BIAS_X = 3'd1,
        REG_BIAS_Y = 3'd2,
        REG_BIAS_Z = 3'd3,
        REG_ROW_0  = 3'd4,
        REG_ROW_1  = 3'd5,
        REG_ROW_2  = 3'd6
    } t_reg_idx;

    // unity coefficient and identity rows
    localparam t_coef COEF_ONE   = COEF_W'(1 << COEF_FRAC_BITS);
    localparam t_row  IDENT_ROW_0 = ROW_W'(COEF_ONE);
    localparam t_row  IDENT_ROW_1 = ROW_W'({COEF_ONE, COEF_W'(0)});
    localparam t_row  IDENT_ROW_2 = ROW_W'({COEF_ONE, COEF_W'(0), COEF_W'(0)});

    // per-stage load enables
    typedef struct packed {
        logic en_diff;
        logic en_prod;
        logic en_sum;
        logic en_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

FILE: hdl/mhsic_front.sv
// ----------------------------------------------------------------------------
// mhsic_front
// hard-iron bias removal, one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module mhsic_front
    import mhsic_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_sample   i_raw  [NUM_AXES],
    input  wire t_sample   i_bias [NUM_AXES],
    output t_diff          o_diff [NUM_AXES]
);

    t_diff r_diff [NUM_AXES];
    t_diff n_diff [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_diff[a] = DIFF_W'(i_raw[a]) - DIFF_W'(i_bias[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_diff) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

`default_nettype wire

FILE: hdl/mhsic_lane.sv
// ----------------------------------------------------------------------------
// mhsic_lane
// one matrix row: three products, then sum with round to nearest
// ----------------------------------------------------------------------------
`default_nettype none

module mhsic_lane
    import mhsic_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_row      i_row,
    input  wire t_diff     i_diff [NUM_AXES],
    output t_sum           o_sum
);

    localparam t_sum HALF = SUM_W'(1 << (COEF_FRAC_BITS - 1));

    t_coef w_coef [NUM_AXES];
    t_prod r_prod [NUM_AXES];
    t_prod n_prod [NUM_AXES];
    t_sum  r_sum;
    t_sum  n_acc;
    t_sum  n_sum;

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            w_coef[c] = i_row[c*COEF_W +: COEF_W];
            n_prod[c] = PROD_W'(w_coef[c]) * PROD_W'(i_diff[c]);
        end
    end

    // add half an lsb, then floor by arithmetic shift
    always_comb begin
        n_acc = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]) + HALF;
        n_sum = n_acc >>> COEF_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            r_prod <= n_prod;
        end
        if (i_ctl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

FILE: hdl/mhsic_merge.sv
// ----------------------------------------------------------------------------
// mhsic_merge
// gathers the lane sums, saturates to the output range, output register
// ----------------------------------------------------------------------------
`default_nettype none

module mhsic_merge
    import mhsic_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire t_sum      i_sum [NUM_AXES],
    output t_out           o_cal [NUM_AXES]
);

    localparam t_sum SAT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam t_sum SAT_LO = -SAT_HI - SUM_W'(1);

    t_out r_cal [NUM_AXES];
    t_out n_cal [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            priority if (i_sum[a] > SAT_HI) begin
                n_cal[a] = OUT_W'(SAT_HI);
            end else if (i_sum[a] < SAT_LO) begin
                n_cal[a] = OUT_W'(SAT_LO);
            end else begin
                n_cal[a] = OUT_W'(i_sum[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

FILE: hdl/mag_hard_soft_iron_correct_core.sv
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_correct_core
// magnetometer hard-iron bias removal and soft-iron 3x3 matrix correction
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 word
// -------   ---------  ------------------------  ---------------------------
// in        sink       i_in_valid / o_in_stall   raw_x, raw_y, raw_z
// out       source     o_out_valid / i_out_stall cal_x, cal_y, cal_z
// cfg       sink       i_cfg_valid / o_cfg_ready register index, write data
//
// one word per cycle sustained while the output is not stalled; four
// register stages (bias subtract, three multipliers per lane, lane sum and
// round, saturate into the output register); o_out_valid rises when a word
// reaches the output register; synchronous active-low reset clears the
// stage valids and loads the config reset values
// an output stall holds the output register; earlier stages keep filling
// bubbles, and o_in_stall rises only once every stage holds a word
// config writes are always taken (o_cfg_ready is tied high)
//
`default_nettype none

module mag_hard_soft_iron_correct_core
    import mhsic_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input words
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_raw_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_raw_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_raw_z,
    // output words
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [OUT_W-1:0]       o_cal_x,
    output logic signed [OUT_W-1:0]       o_cal_y,
    output logic signed [OUT_W-1:0]       o_cal_z,
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ROW_W-1:0]         i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic    r_cal_en;
    t_sample r_bias [NUM_AXES];
    t_row    r_row  [NUM_AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_en <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_bias[a] <= '0;
            end
            r_row[0] <= IDENT_ROW_0;
            r_row[1] <= IDENT_ROW_1;
            r_row[2] <= IDENT_ROW_2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CAL_EN: r_cal_en  <= i_cfg_data[0];
                REG_BIAS_X: r_bias[0] <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_BIAS_Y: r_bias[1] <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_BIAS_Z: r_bias[2] <= i_cfg_data[SAMPLE_WIDTH-1:0];
                REG_ROW_0:  r_row[0]  <= i_cfg_data;
                REG_ROW_1:  r_row[1]  <= i_cfg_data;
                REG_ROW_2:  r_row[2]  <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // with calibration off, zero bias and identity matrix give back the raw
    // sample exactly: raw * 2^frac + half, floored by 2^frac
    t_sample w_bias [NUM_AXES];
    t_row    w_row  [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_bias[a] = r_cal_en ? r_bias[a] : '0;
        end
        w_row[0] = r_cal_en ? r_row[0] : IDENT_ROW_0;
        w_row[1] = r_cal_en ? r_row[1] : IDENT_ROW_1;
        w_row[2] = r_cal_en ? r_row[2] : IDENT_ROW_2;
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic      r_v_diff, r_v_prod, r_v_sum, r_v_out;
    t_pipe_ctl w_ctl;

    always_comb begin
        w_ctl.en_out  = !r_v_out  || !i_out_stall;
        w_ctl.en_sum  = !r_v_sum  || w_ctl.en_out;
        w_ctl.en_prod = !r_v_prod || w_ctl.en_sum;
        w_ctl.en_diff = !r_v_diff || w_ctl.en_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_diff <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_ctl.en_diff) r_v_diff <= i_in_valid;
            if (w_ctl.en_prod) r_v_prod <= r_v_diff;
            if (w_ctl.en_sum)  r_v_sum  <= r_v_prod;
            if (w_ctl.en_out)  r_v_out  <= r_v_sum;
        end
    end

    assign o_in_stall  = !w_ctl.en_diff;
    assign o_out_valid = r_v_out;

    // ------------------------------------------------------------------
    // datapath: front stage, one lane per output axis, merge stage
    // ------------------------------------------------------------------
    t_sample w_raw  [NUM_AXES];
    t_diff   w_diff [NUM_AXES];
    t_sum    w_sum  [NUM_AXES];
    t_out    w_cal  [NUM_AXES];

    assign w_raw[0] = i_raw_x;
    assign w_raw[1] = i_raw_y;
    assign w_raw[2] = i_raw_z;

    mhsic_front u_front (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_raw  (w_raw),
        .i_bias (w_bias),
        .o_diff (w_diff)
    );

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        mhsic_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_row  (w_row[g]),
            .i_diff (w_diff),
            .o_sum  (w_sum[g])
        );
    end

    mhsic_merge u_merge (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_sum (w_sum),
        .o_cal (w_cal)
    );

    assign o_cal_x = w_cal[0];
    assign o_cal_y = w_cal[1];
    assign o_cal_z = w_cal[2];

endmodule

`default_nettype wire
